@@ rtl/core/sos_beacon_sequencer_assert.svh @@
// Assertion macros used by the beacon sequencer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef SOS_BEACON_SEQUENCER_ASSERT_SVH
`define SOS_BEACON_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
`define SOS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sos_beacon_sequencer: same-cycle check failed");
`define SOS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sos_beacon_sequencer: next-cycle check failed");
`else
`define SOS_ASSERT_SAME(label, ante, cons)
`define SOS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/sos_pkg.sv @@
`default_nettype none
package sos_pkg;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_EVAL    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_PREPARE    = 3'd0,
    PH_DOTS       = 3'd1,
    PH_DOT_GAP    = 3'd2,
    PH_DASHES     = 3'd3,
    PH_DASH_GAP   = 3'd4,
    PH_DOTS_AGAIN = 3'd5,
    PH_FINISH     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    REG_DOT_TICKS    = 2'd0,
    REG_DASH_TICKS   = 2'd1,
    REG_LETTER_GAP   = 2'd2,
    REG_FINISH_GAP   = 2'd3
  } reg_index_t;

  localparam int UNIT_W  = 6;
  localparam int TIMER_W = 8;
  localparam int GEAR_W  = 15;
  localparam int DIV_STEPS = TIMER_W;
  localparam int CNT_W   = $clog2(DIV_STEPS);

  localparam logic [UNIT_W-1:0]  DOT_RESET    = 6'd3;
  localparam logic [UNIT_W-1:0]  DASH_RESET   = 6'd9;
  localparam logic [TIMER_W-1:0] LETTER_RESET = 8'd10;
  localparam logic [TIMER_W-1:0] FINISH_RESET = 8'd30;

  // Length of a three-symbol run: 6*unit-1 (0 for a zero unit), clamped to the timer range.
  function automatic logic [TIMER_W-1:0] run_length(input logic [UNIT_W-1:0] unit);
    logic [UNIT_W+2:0] n;
    n = {1'b0, unit, 2'b00} + {2'b00, unit, 1'b0};
    if (n == '0) begin
      return '0;
    end
    n = n - 1'b1;
    if (n > {{(UNIT_W+3-TIMER_W){1'b0}}, {TIMER_W{1'b1}}}) begin
      return {TIMER_W{1'b1}};
    end
    return n[TIMER_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sos_beacon_sequencer.sv @@
`default_nettype none
// SOS beacon sequencer. Each input word carries an action (tick, evaluate,
// restart) in tuser and a gear current in tdata; every accepted word yields
// exactly one result word with the drive current and the lamp flag. Tick,
// restart and the unused action go from idle straight to the done state,
// from which their result word is loaded into the output register. Every
// evaluate, in any phase, runs the shift-subtract remainder unit that works out
// timer mod (2*unit) one bit per cycle over the 8 timer bits and then moves to
// the done state, from which its result word is loaded into the output register.
// A stalled output register holds the sequencer in its last cycle until the
// waiting word leaves. A new word is accepted once the previous one has left
// the sequencer, even while its result still waits in the output register.
// Configuration writes are always taken and must only be issued while the
// block is idle.
`include "sos_beacon_sequencer_assert.svh"
module sos_beacon_sequencer import sos_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  input  wire logic [15:0] in_tdata,   // [14:0] gear_current, [15] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [14:0] drive_current, [15] lamp_on
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [UNIT_W-1:0]  dot_ticks_r, dash_ticks_r;
  logic [TIMER_W-1:0] letter_gap_r, finish_gap_r;

  seq_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;

  action_t             action_r;
  logic [GEAR_W-1:0]   gear_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TIMER_W-1:0]  dvd_r;
  logic [UNIT_W:0]     rem_r;

  logic                out_valid_r;
  logic [GEAR_W-1:0]   drive_r;
  logic                lamp_r;

  logic                accept;
  logic                out_free;
  logic                finish;
  logic                sym_phase;
  logic                dash_phase;
  logic [UNIT_W-1:0]   unit;
  logic [UNIT_W:0]     divisor;
  logic [UNIT_W+1:0]   trial;
  logic [UNIT_W+1:0]   trial_diff;
  logic [UNIT_W:0]     rem_step;
  logic                lit;
  action_t             in_action;

  assign cfg_ready  = 1'b1;
  assign in_action  = action_t'(in_tuser);
  assign out_free   = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign finish     = (state_r == ST_DONE) && out_free;

  assign dash_phase = (phase_r == PH_DASHES);
  assign sym_phase  = (phase_r == PH_DOTS) || (phase_r == PH_DOTS_AGAIN) || dash_phase;
  assign unit       = dash_phase ? dash_ticks_r : dot_ticks_r;
  assign divisor    = {unit, 1'b0};

  // One restoring step of the remainder; the remainder stays below a nonzero divisor.
  assign trial      = {rem_r, dvd_r[TIMER_W-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign rem_step   = (trial >= {1'b0, divisor}) ? trial_diff[UNIT_W:0] : trial[UNIT_W:0];

  assign lit = (action_r == ACT_EVAL) && sym_phase && (unit != '0)
               && (rem_r >= {1'b0, unit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_ticks_r  <= DOT_RESET;
      dash_ticks_r <= DASH_RESET;
      letter_gap_r <= LETTER_RESET;
      finish_gap_r <= FINISH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_DOT_TICKS:  dot_ticks_r  <= cfg_data[UNIT_W-1:0];
        REG_DASH_TICKS: dash_ticks_r <= cfg_data[UNIT_W-1:0];
        REG_LETTER_GAP: letter_gap_r <= cfg_data;
        REG_FINISH_GAP: finish_gap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (in_action == ACT_EVAL) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Effect of the word on phase and timer, applied when the result is loaded into the output register.
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    case (action_r)
      ACT_TICK: begin
        if (timer_r != '0) begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      ACT_RESTART: begin
        phase_nxt = PH_PREPARE;
        timer_nxt = '0;
      end
      ACT_EVAL: begin
        unique case (phase_r)
          PH_PREPARE: begin
            phase_nxt = PH_DOTS;
            timer_nxt = run_length(dot_ticks_r);
          end
          PH_DOTS: begin
            if (!lit && timer_r == '0) begin
              phase_nxt = PH_DOT_GAP;
              timer_nxt = letter_gap_r;
            end
          end
          PH_DOT_GAP: begin
            if (timer_r == '0) begin
              phase_nxt = PH_DASHES;
              timer_nxt = run_length(dash_ticks_r);
            end
          end
          PH_DASHES: begin
            if (!lit && timer_r == '0) begin
              phase_nxt = PH_DASH_GAP;
              timer_nxt = letter_gap_r;
            end
          end
          PH_DASH_GAP: begin
            if (timer_r == '0) begin
              phase_nxt = PH_DOTS_AGAIN;
              timer_nxt = run_length(dot_ticks_r);
            end
          end
          PH_DOTS_AGAIN: begin
            if (!lit && timer_r == '0) begin
              phase_nxt = PH_FINISH;
              timer_nxt = finish_gap_r;
            end
          end
          default: begin
            if (timer_r == '0) begin
              phase_nxt = PH_PREPARE;
              timer_nxt = '0;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_PREPARE;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        phase_r     <= phase_nxt;
        timer_r     <= timer_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        cnt_r <= CNT_W'(DIV_STEPS - 1);
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      gear_r   <= in_tdata[GEAR_W-1:0];
      dvd_r    <= timer_r;
      rem_r    <= '0;
    end else if (state_r == ST_DIV) begin
      dvd_r <= {dvd_r[TIMER_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
    if (finish) begin
      drive_r <= lit ? gear_r : '0;
      lamp_r  <= lit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {lamp_r, drive_r};

  `SOS_ASSERT_NEXT(a_timer_holds, state_r != ST_DONE, $stable(timer_r))
  `SOS_ASSERT_NEXT(a_div_ends, state_r == ST_DIV && cnt_r == '0, state_r == ST_DONE)
  `SOS_ASSERT_NEXT(a_result_lands, finish, out_valid_r && state_r == ST_IDLE)
  `SOS_ASSERT_SAME(a_lit_in_run, out_valid_r && lamp_r,
                   phase_r == PH_DOTS || phase_r == PH_DASHES || phase_r == PH_DOTS_AGAIN)

endmodule
`default_nettype wire
